### sv/rcpw_pkg.sv
package rcpw_pkg;

  typedef enum logic {
    KIND_EDGE = 1'b0,
    KIND_POLL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PULSE_MIN  = 2'd0,
    CFG_PULSE_MAX  = 2'd1,
    CFG_MODE_THR   = 2'd2,
    CFG_TIMEOUT    = 2'd3
  } cfg_idx_e;

  localparam int unsigned NumCh     = 3;
  localparam int unsigned UsW       = 12;
  localparam int unsigned StampW    = 16;
  localparam int unsigned FramesW   = 8;
  localparam int unsigned CfgW      = 12;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [1:0] ChMode = 2'd2;

  localparam logic [UsW-1:0]     PulseMinReset = 12'd900;
  localparam logic [UsW-1:0]     PulseMaxReset = 12'd2100;
  localparam logic [UsW-1:0]     ModeThrReset  = 12'd1450;
  localparam logic [FramesW-1:0] TimeoutReset  = 8'd5;
  localparam logic [FramesW-1:0] FramesMax     = 8'd255;

  localparam logic [UsW-1:0] HeldReset [NumCh] = '{12'd1500, 12'd1500, 12'd2000};

  typedef struct packed {
    logic              kind;
    logic [1:0]        channel;
    logic [StampW-1:0] stamp;
  } in_t;

  typedef struct packed {
    logic [UsW-1:0] steer_us;
    logic [UsW-1:0] throttle_us;
    logic [UsW-1:0] mode_us;
    logic           manual;
    logic           pulse_ok;
  } out_t;

endpackage

### sv/rcpw_chan_if.sv
interface rcpw_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/rc_pulse_width_capture.sv
// channel   direction  payload                                      handshake
// in_i      in         kind, channel, stamp                         valid/ready
// out_o     out        steer_us, throttle_us, mode_us, manual,      valid/ready
//                      pulse_ok
// cfg       in         cfg_idx_i, cfg_wdata_i                       cfg_we_i
//
// one item per cycle while the result is free or taken; each item's result is valid in the cycle after it is accepted
// state and the result register update at the same edge, single pass
// reset: widths 1500/1500/2000, manual mode, no channel awaiting a fall
// a stalled result holds; a new item is taken when the result is free or taken
// tick limits are precomputed at config write, so width math is one multiply
module rc_pulse_width_capture #(
  parameter int unsigned TicksPerUs = 50
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rcpw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rcpw_pkg::CfgW-1:0]    cfg_wdata_i,
  rcpw_chan_if.sink                    in_i,
  rcpw_chan_if.source                  out_o
);
  import rcpw_pkg::*;

  localparam int unsigned TpuW    = (TicksPerUs > 1) ? $clog2(TicksPerUs) : 0;
  localparam int unsigned TickW   = (UsW + TpuW > StampW + 1) ? UsW + TpuW : StampW + 1;
  localparam int unsigned DivSh   = StampW + 1 + TpuW;
  localparam int unsigned RecipW  = DivSh + 1;
  localparam longint unsigned RecipVal =
      ((longint'(1) << DivSh) + TicksPerUs - 1) / TicksPerUs;
  localparam int unsigned ProdW   = StampW + 1 + RecipW;
  localparam longint unsigned MinTicksRst = 900 * TicksPerUs;
  localparam longint unsigned MaxTicksRst = 2100 * TicksPerUs;
  localparam longint unsigned WrapRst =
      (MaxTicksRst > 65536) ? MaxTicksRst - 65536 : 0;

  logic [UsW-1:0]     min_us_q, max_us_q, thr_us_q;
  logic [FramesW-1:0] timeout_q;
  logic [TickW-1:0]   min_ticks_q, max_ticks_d, wrap_lim_q, wrap_lim_d;
  logic               wrap_en_q, wrap_en_d;

  logic [StampW-1:0]  rise_q [NumCh];
  logic [NumCh-1:0]   await_q, await_d;
  logic [UsW-1:0]     held_q [NumCh];
  logic [UsW-1:0]     held_d [NumCh];
  logic               newmode_q, newmode_d;
  logic [FramesW-1:0] silent_q, silent_d;
  logic               manual_q, manual_d;

  out_t               out_q, out_d;
  logic               out_valid_q;

  logic               in_fire;
  logic               edge_ev;
  logic [StampW-1:0]  rise_sel;
  logic [StampW-1:0]  diff;
  logic [StampW:0]    ticks;
  logic               tick_rej;
  logic [ProdW-1:0]   prod;
  logic [StampW:0]    us;
  logic               us_ok;
  logic               fall_ok;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // config registers and derived tick limits
  assign max_ticks_d = TickW'(cfg_wdata_i) * TickW'(TicksPerUs);
  assign wrap_en_d   = max_ticks_d > TickW'(65535);
  assign wrap_lim_d  = (max_ticks_d > TickW'(65536)) ? max_ticks_d - TickW'(65536)
                                                     : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_us_q    <= PulseMinReset;
      max_us_q    <= PulseMaxReset;
      thr_us_q    <= ModeThrReset;
      timeout_q   <= TimeoutReset;
      min_ticks_q <= TickW'(MinTicksRst);
      wrap_lim_q  <= TickW'(WrapRst);
      wrap_en_q   <= MaxTicksRst > 65535;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PULSE_MIN: begin
          min_us_q    <= cfg_wdata_i;
          min_ticks_q <= max_ticks_d;
        end
        CFG_PULSE_MAX: begin
          max_us_q   <= cfg_wdata_i;
          wrap_lim_q <= wrap_lim_d;
          wrap_en_q  <= wrap_en_d;
        end
        CFG_MODE_THR: thr_us_q  <= cfg_wdata_i;
        CFG_TIMEOUT:  timeout_q <= cfg_wdata_i[FramesW-1:0];
        default: ;
      endcase
    end
  end

  // width measurement
  always_comb begin
    rise_sel = '0;
    for (int i = 0; i < NumCh; i++) begin
      if (in_i.data.channel == 2'(i)) rise_sel = rise_q[i];
    end
  end

  assign diff = in_i.data.stamp - rise_sel;

  always_comb begin
    ticks    = {1'b0, diff};
    tick_rej = 1'b0;
    if (wrap_en_q) begin
      if (TickW'(diff) <= wrap_lim_q) begin
        ticks = {1'b1, diff};
      end else if (TickW'(diff) < min_ticks_q) begin
        tick_rej = 1'b1;
      end
    end
    if (ticks == '0) tick_rej = 1'b1;
  end

  assign prod    = ProdW'(ticks) * ProdW'(RecipVal);
  assign us      = prod[DivSh +: StampW + 1];
  assign us_ok   = (us >= (StampW + 1)'(min_us_q)) && (us <= (StampW + 1)'(max_us_q));
  assign edge_ev = (in_i.data.kind == KIND_EDGE) && (in_i.data.channel != 2'd3);

  // next state and result
  always_comb begin
    await_d   = await_q;
    held_d    = held_q;
    newmode_d = newmode_q;
    silent_d  = silent_q;
    manual_d  = manual_q;
    fall_ok   = 1'b0;
    if (in_i.data.kind == KIND_POLL) begin
      if (newmode_q) begin
        silent_d  = '0;
        newmode_d = 1'b0;
      end else if (silent_q != FramesMax) begin
        silent_d = silent_q + 1'b1;
      end
      manual_d = (silent_d >= timeout_q) || (held_q[ChMode] >= thr_us_q);
    end else if (edge_ev) begin
      for (int i = 0; i < NumCh; i++) begin
        if (in_i.data.channel == 2'(i)) begin
          await_d[i] = !await_q[i];
          if (await_q[i] && !tick_rej && us_ok) begin
            held_d[i] = us[UsW-1:0];
            fall_ok   = 1'b1;
            if (2'(i) == ChMode) newmode_d = 1'b1;
          end
        end
      end
    end
    out_d.steer_us    = held_d[0];
    out_d.throttle_us = held_d[1];
    out_d.mode_us     = held_d[2];
    out_d.manual      = manual_d;
    out_d.pulse_ok    = fall_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCh; i++) begin
        rise_q[i] <= '0;
        held_q[i] <= HeldReset[i];
      end
      await_q     <= '0;
      newmode_q   <= 1'b0;
      silent_q    <= '0;
      manual_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        for (int i = 0; i < NumCh; i++) begin
          if (edge_ev && in_i.data.channel == 2'(i) && !await_q[i]) begin
            rise_q[i] <= in_i.data.stamp;
          end
        end
        await_q   <= await_d;
        held_q    <= held_d;
        newmode_q <= newmode_d;
        silent_q  <= silent_d;
        manual_q  <= manual_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) out_q <= out_d;
  end

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted item produced no result");

  a_poll_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.kind == KIND_POLL |=> !out_q.pulse_ok && $stable(await_q))
    else $error("poll changed edge state or flagged a pulse");

  a_poll_clears_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.kind == KIND_POLL && newmode_q |=> silent_q == '0 && !newmode_q)
    else $error("poll after new mode pulse did not clear frame count");

  a_unused_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.data.kind == KIND_EDGE && in_i.data.channel == 2'd3
    |=> !out_q.pulse_ok && $stable(await_q) && $stable(newmode_q))
    else $error("unused channel changed state");

  a_manual_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.manual == manual_q)
    else $error("result manual bit differs from held decision");

endmodule

### bench/tb_top.sv
module tb_top ();
  timeunit 1ns;
  timeprecision 1ps;
  import rcpw_pkg::*;

  localparam int unsigned TicksPerUs = 50;
  localparam int unsigned CycleLimit = 500_000;
  localparam int unsigned ShowLimit  = 10;
  localparam int unsigned SettleCyc  = 4;

  localparam logic [1:0] ChSteer    = 2'd0;
  localparam logic [1:0] ChThrottle = 2'd1;
  localparam logic [1:0] ChNone     = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_wdata_i;

  rcpw_chan_if #(.T(in_t))  in_if ();
  rcpw_chan_if #(.T(out_t)) out_if ();

  rc_pulse_width_capture #(
    .TicksPerUs(TicksPerUs)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predicted block state
  logic [UsW-1:0]     cfg_min;
  logic [UsW-1:0]     cfg_max;
  logic [UsW-1:0]     cfg_thr;
  logic [FramesW-1:0] cfg_timeout;
  logic [StampW-1:0]  rise_at [NumCh];
  logic               waiting_fall [NumCh];
  logic [UsW-1:0]     held_us [NumCh];
  logic               mode_fresh;
  logic [FramesW-1:0] silent_cnt;
  logic               manual_q;

  out_t pending_readings [$];

  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned n_items;
  int unsigned n_polls;
  int unsigned n_accepted;
  int unsigned n_cfg;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned cycle_count;

  // accepted width in us, zero when rejected
  function automatic logic [UsW-1:0] pulse_us(input logic [StampW-1:0] t0,
                                              input logic [StampW-1:0] t1);
    logic [StampW-1:0] d16;
    int unsigned ticks;
    int unsigned max_t;
    int unsigned min_t;
    int unsigned wrap;
    int unsigned us;
    d16   = t1 - t0;
    ticks = d16;
    max_t = cfg_max * TicksPerUs;
    min_t = cfg_min * TicksPerUs;
    if (max_t > 32'd65535) begin
      wrap = (max_t > 32'd65536) ? max_t - 32'd65536 : 32'd0;
      if (ticks <= wrap) begin
        ticks += 32'd65536;
      end else if (ticks < min_t) begin
        return '0;
      end
    end
    if (ticks == 0) return '0;
    us = ticks / TicksPerUs;
    if (us < cfg_min || us > cfg_max) return '0;
    return us[UsW-1:0];
  endfunction

  function automatic out_t predict_reading(input in_t it);
    out_t r;
    logic [UsW-1:0] us;
    r.pulse_ok = 1'b0;
    if (it.kind == KIND_POLL) begin
      n_polls++;
      if (mode_fresh) begin
        silent_cnt = '0;
        mode_fresh = 1'b0;
      end else if (silent_cnt != FramesMax) begin
        silent_cnt++;
      end
      manual_q = (silent_cnt >= cfg_timeout) || (held_us[ChMode] >= cfg_thr);
    end else if (it.channel != ChNone) begin
      if (!waiting_fall[it.channel]) begin
        rise_at[it.channel]      = it.stamp;
        waiting_fall[it.channel] = 1'b1;
      end else begin
        us = pulse_us(rise_at[it.channel], it.stamp);
        if (us != '0) begin
          held_us[it.channel] = us;
          r.pulse_ok = 1'b1;
          n_accepted++;
          if (it.channel == ChMode) mode_fresh = 1'b1;
        end
        waiting_fall[it.channel] = 1'b0;
      end
    end
    r.steer_us    = held_us[ChSteer];
    r.throttle_us = held_us[ChThrottle];
    r.mode_us     = held_us[ChMode];
    r.manual      = manual_q;
    return r;
  endfunction

  // mostly well-formed rise/fall pairs sized around the limits, some polls and noise
  function automatic in_t random_item();
    in_t it;
    int unsigned pick;
    int unsigned ticks;
    int unsigned lo;
    int unsigned hi;
    logic [1:0] ch;
    it.kind    = KIND_EDGE;
    it.channel = 2'($urandom);
    it.stamp   = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      it.kind = KIND_POLL;
    end else if (pick < 28) begin
      it.kind = 1'($urandom);
    end else begin
      ch = 2'($urandom_range(0, NumCh - 1));
      it.channel = ch;
      if (waiting_fall[ch]) begin
        lo = (cfg_min < cfg_max) ? cfg_min : cfg_max;
        hi = (cfg_min < cfg_max) ? cfg_max : cfg_min;
        case ($urandom_range(0, 9))
          0: ticks = $urandom_range(0, 140000);
          1: begin
            case ($urandom_range(0, 3))
              0: ticks = cfg_min * TicksPerUs;
              1: ticks = cfg_max * TicksPerUs;
              2: ticks = (cfg_min - 1) * TicksPerUs;
              default: ticks = (cfg_max + 1) * TicksPerUs;
            endcase
            ticks += $urandom_range(0, TicksPerUs - 1);
          end
          default: ticks = $urandom_range(lo, hi) * TicksPerUs +
                           $urandom_range(0, TicksPerUs - 1);
        endcase
        it.stamp = rise_at[ch] + ticks[StampW-1:0];
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_t it);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_readings.push_back(predict_reading(it));
    n_items++;
  endtask

  task automatic send_edge(input logic [1:0] ch, input logic [StampW-1:0] stamp);
    send_item(in_t'{kind: KIND_EDGE, channel: ch, stamp: stamp});
  endtask

  task automatic send_poll();
    send_item(in_t'{kind: KIND_POLL, channel: 2'($urandom), stamp: 16'($urandom)});
  endtask

  // closes an open pulse first so the rise lands where intended
  task automatic pulse(input logic [1:0] ch, input logic [StampW-1:0] t0,
                       input int unsigned ticks);
    if (waiting_fall[ch]) send_edge(ch, t0);
    send_edge(ch, t0);
    send_edge(ch, t0 + ticks[StampW-1:0]);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[CfgW-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_PULSE_MIN: cfg_min = value[UsW-1:0];
      CFG_PULSE_MAX: cfg_max = value[UsW-1:0];
      CFG_MODE_THR:  cfg_thr = value[UsW-1:0];
      CFG_TIMEOUT:   cfg_timeout = value[FramesW-1:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_limits(input int unsigned lo_us, input int unsigned hi_us,
                            input int unsigned thr_us, input int unsigned frames);
    settle();
    write_reg(CFG_PULSE_MIN, lo_us);
    write_reg(CFG_PULSE_MAX, hi_us);
    write_reg(CFG_MODE_THR, thr_us);
    write_reg(CFG_TIMEOUT, frames);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_poll();
    pulse(ChSteer, 16'h0000, 1500 * TicksPerUs);
    pulse(ChThrottle, 16'd100, 900 * TicksPerUs);
    pulse(ChThrottle, 16'd100, 900 * TicksPerUs - 1);
    pulse(ChSteer, 16'hFFFF, 2100 * TicksPerUs);
    pulse(ChSteer, 16'hFFFF, 2101 * TicksPerUs);
    pulse(ChMode, 16'h8000, 1000 * TicksPerUs);
    send_edge(ChNone, 16'hFFFF);
    send_poll();
    pulse(ChMode, 16'h0000, 0);
    repeat (6) send_poll();
  endtask

  task automatic test_limit_extremes();
    set_limits(1, 1, 0, 0);
    pulse(ChSteer, 16'h0000, 0);
    pulse(ChThrottle, 16'hFFFF, TicksPerUs);
    pulse(ChMode, 16'h1234, TicksPerUs - 1);
    send_poll();
    repeat (40) send_item(random_item());
    // last limit without the wrap path, then the first one with it
    set_limits(1, 1310, 700, 3);
    pulse(ChSteer, 16'h0000, 1310 * TicksPerUs);
    pulse(ChSteer, 16'hFFF0, 0);
    repeat (30) send_item(random_item());
    set_limits(1, 1311, 700, 3);
    pulse(ChSteer, 16'hFFF0, 14);
    pulse(ChThrottle, 16'd5, 15);
    repeat (30) send_item(random_item());
    set_limits(2000, 1000, 1500, 2);
    pulse(ChSteer, 16'h0000, 1500 * TicksPerUs);
    repeat (40) send_item(random_item());
  endtask

  task automatic test_poll_saturation();
    set_limits(2600, 2600, 2600, 255);
    repeat (300) send_poll();
    pulse(ChMode, 16'h0100, 2600 * TicksPerUs);
    pulse(ChMode, 16'h0100, 2601 * TicksPerUs);
    repeat (2) send_poll();
  endtask

  task automatic test_random_traffic();
    int unsigned sender_pct [4] = '{0, 78, 0, 8};
    int unsigned recv_pct [4] = '{0, 0, 78, 8};
    for (int ph = 0; ph < 4; ph++) begin
      set_limits($urandom_range(600, 1300), $urandom_range(1000, 2600),
                 $urandom_range(500, 2200), $urandom_range(0, 8));
      idle_pct  = sender_pct[ph];
      stall_pct = recv_pct[ph];
      repeat (250) begin
        if ($urandom_range(0, 99) == 0) settle();
        send_item(random_item());
      end
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_readings.size() == 0) begin
        n_errors++;
        if (n_errors <= ShowLimit) $display("result with no item pending");
      end else begin
        out_t want;
        want = pending_readings.pop_front();
        if (out_if.data.steer_us !== want.steer_us ||
            out_if.data.throttle_us !== want.throttle_us ||
            out_if.data.mode_us !== want.mode_us ||
            out_if.data.manual !== want.manual ||
            out_if.data.pulse_ok !== want.pulse_ok) begin
          n_errors++;
          if (n_errors <= ShowLimit) begin
            $display("mismatch on result %0d: exp steer %0d thr %0d mode %0d man %b ok %b",
                     n_checked, want.steer_us, want.throttle_us, want.mode_us,
                     want.manual, want.pulse_ok);
            $display("                        got steer %0d thr %0d mode %0d man %b ok %b",
                     out_if.data.steer_us, out_if.data.throttle_us, out_if.data.mode_us,
                     out_if.data.manual, out_if.data.pulse_ok);
          end
        end
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[rc_pulse_width_capture] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_wdata_i <= '0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    cfg_min     = PulseMinReset;
    cfg_max     = PulseMaxReset;
    cfg_thr     = ModeThrReset;
    cfg_timeout = TimeoutReset;
    for (int c = 0; c < NumCh; c++) begin
      rise_at[c]      = '0;
      waiting_fall[c] = 1'b0;
      held_us[c]      = HeldReset[c];
    end
    mode_fresh = 1'b0;
    silent_cnt = '0;
    manual_q   = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_limit_extremes();
    test_poll_saturation();
    test_random_traffic();

    settle();
    n_errors += pending_readings.size();
    $display("%0d items (%0d frame polls, %0d widths accepted), %0d register writes,",
             n_items, n_polls, n_accepted, n_cfg);
    $display("limit extremes, timer wrap, poll counter saturation, idle and stall phases");
    if (n_errors == 0) begin
      $display("[rc_pulse_width_capture] OK");
    end else begin
      $display("[rc_pulse_width_capture] ERROR");
    end
    $finish;
  end

endmodule
